// File: rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// shared types, token kinds, keyword table and helpers for the lexer
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int LINE_BITS_DEFAULT     = 16;

  // token queue between scanner and output port
  localparam int QUEUE_DEPTH = 6;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_PUSH    = 3;

  // token kinds
  localparam logic [4:0] K_IDENT   = 5'd0;
  localparam logic [4:0] K_INTEGER = 5'd1;
  localparam logic [4:0] K_KW_INT  = 5'd2;
  localparam logic [4:0] K_PLUS    = 5'd8;
  localparam logic [4:0] K_INC     = 5'd9;
  localparam logic [4:0] K_MINUS   = 5'd10;
  localparam logic [4:0] K_DEC     = 5'd11;
  localparam logic [4:0] K_ASSIGN  = 5'd12;
  localparam logic [4:0] K_TILDE   = 5'd13;
  localparam logic [4:0] K_BAR     = 5'd14;
  localparam logic [4:0] K_STAR    = 5'd15;
  localparam logic [4:0] K_SLASH   = 5'd16;
  localparam logic [4:0] K_LT      = 5'd17;
  localparam logic [4:0] K_GT      = 5'd18;
  localparam logic [4:0] K_SEMI    = 5'd19;
  localparam logic [4:0] K_LBRACE  = 5'd20;
  localparam logic [4:0] K_RBRACE  = 5'd21;
  localparam logic [4:0] K_LPAREN  = 5'd22;
  localparam logic [4:0] K_RPAREN  = 5'd23;
  localparam logic [4:0] K_STRLIT  = 5'd24;
  localparam logic [4:0] K_CHARLIT = 5'd25;
  localparam logic [4:0] K_UNKNOWN = 5'd26;
  localparam logic [4:0] K_END     = 5'd27;

  // keywords: int string char print if while
  localparam int KW_COUNT = 6;
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd6, 3'd4, 3'd5, 3'd2, 3'd5};

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [7:0]  value;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0]          count;
    token_t [MAX_PUSH-1:0] tok;
  } push_t;

  function automatic logic [15:0] sat16(input logic [31:0] x);
    return (x > 32'h0000_FFFF) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic token_t pack_token(input logic [4:0] kind, input logic [31:0] start,
                                        input logic [31:0] length, input logic [31:0] line,
                                        input logic [7:0] value, input logic last);
    token_t t;
    t.kind   = kind;
    t.start  = sat16(start);
    t.length = sat16(length);
    t.line   = sat16(line);
    t.value  = value;
    t.last   = last;
    return t;
  endfunction

  // candidates still matching after byte b at offset k
  function automatic logic [KW_COUNT-1:0] kw_match(input logic [7:0] b, input logic ok,
                                                   input logic [2:0] k);
    logic [KW_COUNT-1:0] m;
    m = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      m[i] = ok && (k < KW_LEN[i]) && (KW_TEXT[i][k] == b);
    end
    return m;
  endfunction

  function automatic logic [4:0] ident_kind(input logic [KW_COUNT-1:0] cand, input logic ok,
                                            input logic [2:0] len);
    logic [4:0] kind;
    kind = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (cand[i] && ok && len == KW_LEN[i]) begin
        kind = K_KW_INT + 5'(i);
      end
    end
    return kind;
  endfunction

endpackage

// File: rtl/small_language_lexer.sv
// ----------------------------------------------------------------------------
// small_language_lexer
// a token is written into the queue when the byte that completes it is taken
// throughput: one byte per cycle while the token queue has room for three tokens
// a byte can release up to three tokens, which leave at one per cycle while token_ready is high
// reset: rst clears the scanner to idle at offset 0, line 1, and empties the queue
// ----------------------------------------------------------------------------
module small_language_lexer import sll_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
  parameter int LINE_BITS     = LINE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] text_start,
  output logic [15:0] text_length,
  output logic [15:0] source_line,
  output logic [7:0]  value_byte,
  output logic        end_of_tokens
);

  push_t              push;
  token_t             head;
  logic [LEVEL_W-1:0] level;
  logic               take;
  logic               pop;

  assign text_ready  = level <= LEVEL_W'(QUEUE_DEPTH - MAX_PUSH);
  assign take        = text_valid && text_ready;
  assign token_valid = level != '0;
  assign pop         = token_valid && token_ready;

  sll_scan #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_byte),
    .final_byte(final_byte),
    .take      (take),
    .push      (push)
  );

  sll_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .level(level)
  );

  assign token_kind    = head.kind;
  assign text_start    = head.start;
  assign text_length   = head.length;
  assign source_line   = head.line;
  assign value_byte    = head.value;
  assign end_of_tokens = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(QUEUE_DEPTH))
    else $error("token queue overfilled");

  a_final_gives_token: assert property (@(posedge clk) disable iff (rst)
    take && final_byte |=> token_valid)
    else $error("no token after last byte");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    token_valid && end_of_tokens |-> token_kind == K_END)
    else $error("end flag on non-end token");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> source_line != 16'd0)
    else $error("token with line zero");

endmodule

// File: rtl/sll_scan.sv
// ----------------------------------------------------------------------------
// sll_scan
// per-byte scanner state and token generation, up to three tokens a byte
// ----------------------------------------------------------------------------
module sll_scan import sll_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
  parameter int LINE_BITS     = LINE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  input  logic       take,
  output push_t      push
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_PLUS    = 4'd3;
  localparam logic [3:0] M_MINUS   = 4'd4;
  localparam logic [3:0] M_SLASH   = 4'd5;
  localparam logic [3:0] M_COMMENT = 4'd6;
  localparam logic [3:0] M_STRING  = 4'd7;
  localparam logic [3:0] M_CHAR1   = 4'd8;
  localparam logic [3:0] M_CHAR2   = 4'd9;

  localparam logic [POSITION_BITS-1:0] SMALL_OFF = POSITION_BITS'(8);

  logic [3:0]               mode, mode_next;
  logic [7:0]               held, held_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] tbeg, tbeg_next;
  logic [LINE_BITS-1:0]     line, line_next;
  logic [KW_COUNT-1:0]      cand, cand_next;

  logic [7:0] b;
  logic       is_alpha, is_digit, is_word;
  logic [7:0] lower;
  logic [POSITION_BITS-1:0] p_inc, off, len_fin;

  // what an idle scanner does with this byte
  logic [3:0]               i_mode;
  logic [POSITION_BITS-1:0] i_tbeg;
  logic [KW_COUNT-1:0]      i_cand;
  logic                     i_line_up, i_emit;
  logic [4:0]               i_kind;
  logic [7:0]               i_val;

  logic [LINE_BITS-1:0] ln;
  logic [1:0]           n;
  token_t [MAX_PUSH-1:0] tok;
  logic                 do_idle;

  assign b        = text_byte;
  assign lower    = b | 8'h20;
  assign is_alpha = (lower >= "a") && (lower <= "z");
  assign is_digit = (b >= "0") && (b <= "9");
  assign is_word  = is_alpha || is_digit || (b == "_");
  assign p_inc    = (pos != '1) ? pos + 1'b1 : pos;
  assign off      = pos - tbeg;

  always_comb begin
    i_mode    = M_IDLE;
    i_tbeg    = tbeg;
    i_cand    = cand;
    i_line_up = 1'b0;
    i_emit    = 1'b0;
    i_kind    = K_UNKNOWN;
    i_val     = 8'h00;
    if (is_alpha || b == "_") begin
      i_mode = M_IDENT;
      i_tbeg = pos;
      i_cand = kw_match(b, 1'b1, 3'd0);
    end else if (is_digit) begin
      i_mode = M_NUMBER;
      i_tbeg = pos;
    end else begin
      case (b) inside
        8'h20, 8'h09, 8'h0D, 8'h00: ;
        8'h0A: i_line_up = 1'b1;
        "+": begin
          i_mode = M_PLUS;
          i_tbeg = pos;
        end
        "-": begin
          i_mode = M_MINUS;
          i_tbeg = pos;
        end
        "/": begin
          i_mode = M_SLASH;
          i_tbeg = pos;
        end
        8'h22: begin
          i_mode = M_STRING;
          i_tbeg = p_inc;
        end
        8'h27: begin
          i_mode = M_CHAR1;
          i_tbeg = p_inc;
        end
        "=": begin i_emit = 1'b1; i_kind = K_ASSIGN; end
        "~": begin i_emit = 1'b1; i_kind = K_TILDE;  end
        "|": begin i_emit = 1'b1; i_kind = K_BAR;    end
        "*": begin i_emit = 1'b1; i_kind = K_STAR;   end
        "<": begin i_emit = 1'b1; i_kind = K_LT;     end
        ">": begin i_emit = 1'b1; i_kind = K_GT;     end
        ";": begin i_emit = 1'b1; i_kind = K_SEMI;   end
        "{": begin i_emit = 1'b1; i_kind = K_LBRACE; end
        "}": begin i_emit = 1'b1; i_kind = K_RBRACE; end
        "(": begin i_emit = 1'b1; i_kind = K_LPAREN; end
        ")": begin i_emit = 1'b1; i_kind = K_RPAREN; end
        default: begin
          i_emit = 1'b1;
          i_kind = K_UNKNOWN;
          i_val  = b;
        end
      endcase
    end
  end

  always_comb begin
    mode_next = mode;
    held_next = held;
    tbeg_next = tbeg;
    cand_next = cand;
    pos_next  = p_inc;
    ln        = line;
    n         = 2'd0;
    tok       = '0;
    do_idle   = 1'b0;
    len_fin   = '0;

    unique case (mode)
      M_IDENT: begin
        if (is_word) begin
          cand_next = cand & kw_match(b, off < SMALL_OFF, off[2:0]);
        end else begin
          tok[n] = pack_token(ident_kind(cand, off < SMALL_OFF, off[2:0]), 32'(tbeg),
                              32'(off), 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (!is_digit) begin
          tok[n] = pack_token(K_INTEGER, 32'(tbeg), 32'(off), 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_PLUS, M_MINUS: begin
        if (b == ((mode == M_PLUS) ? "+" : "-")) begin
          tok[n] = pack_token((mode == M_PLUS) ? K_INC : K_DEC, 32'(tbeg), 32'd2,
                              32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end else begin
          tok[n] = pack_token((mode == M_PLUS) ? K_PLUS : K_MINUS, 32'(tbeg), 32'd1,
                              32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (b == "/") begin
          mode_next = M_COMMENT;
        end else begin
          tok[n] = pack_token(K_SLASH, 32'(tbeg), 32'd1, 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (b == 8'h0A) begin
          ln = (ln != '1) ? ln + 1'b1 : ln;
          mode_next = M_IDLE;
        end
      end
      M_STRING: begin
        if (b == 8'h22) begin
          tok[n] = pack_token(K_STRLIT, 32'(tbeg), 32'(off), 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end else if (b == 8'h0A) begin
          ln = (ln != '1) ? ln + 1'b1 : ln;
        end
      end
      M_CHAR1: begin
        held_next = b;
        mode_next = M_CHAR2;
      end
      M_CHAR2: begin
        tok[n] = pack_token(K_CHARLIT, 32'(tbeg), 32'd1, 32'(ln), held, 1'b0);
        n = n + 2'd1;
        mode_next = M_IDLE;
      end
      default: do_idle = 1'b1;
    endcase

    if (do_idle) begin
      mode_next = i_mode;
      tbeg_next = i_tbeg;
      cand_next = i_cand;
      if (i_line_up) begin
        ln = (ln != '1) ? ln + 1'b1 : ln;
      end
      if (i_emit) begin
        tok[n] = pack_token(i_kind, 32'(pos), 32'd1, 32'(ln), i_val, 1'b0);
        n = n + 2'd1;
      end
    end

    if (final_byte) begin
      len_fin = p_inc - tbeg_next;
      unique case (mode_next)
        M_IDENT: begin
          tok[n] = pack_token(ident_kind(cand_next, len_fin < SMALL_OFF, len_fin[2:0]),
                              32'(tbeg_next), 32'(len_fin), 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
        end
        M_NUMBER: begin
          tok[n] = pack_token(K_INTEGER, 32'(tbeg_next), 32'(len_fin), 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
        end
        M_PLUS: begin
          tok[n] = pack_token(K_PLUS, 32'(tbeg_next), 32'd1, 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
        end
        M_MINUS: begin
          tok[n] = pack_token(K_MINUS, 32'(tbeg_next), 32'd1, 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
        end
        M_SLASH: begin
          tok[n] = pack_token(K_SLASH, 32'(tbeg_next), 32'd1, 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
        end
        M_STRING: begin
          tok[n] = pack_token(K_STRLIT, 32'(tbeg_next), 32'(len_fin), 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
        end
        M_CHAR1: begin
          tok[n] = pack_token(K_CHARLIT, 32'(tbeg_next), 32'd0, 32'(ln), 8'h00, 1'b0);
          n = n + 2'd1;
        end
        M_CHAR2: begin
          tok[n] = pack_token(K_CHARLIT, 32'(tbeg_next), 32'd1, 32'(ln), held_next, 1'b0);
          n = n + 2'd1;
        end
        default: ;
      endcase
      tok[n] = pack_token(K_END, 32'(p_inc), 32'd0, 32'(ln), 8'h00, 1'b1);
      n = n + 2'd1;
      // back to reset state for the next source
      mode_next = M_IDLE;
      held_next = 8'h00;
      pos_next  = '0;
      tbeg_next = '0;
      cand_next = '1;
      ln        = LINE_BITS'(1);
    end
    line_next = ln;
  end

  assign push = {(take ? n : 2'd0), tok};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      held <= 8'h00;
      pos  <= '0;
      tbeg <= '0;
      line <= LINE_BITS'(1);
      cand <= '1;
    end else if (take) begin
      mode <= mode_next;
      held <= held_next;
      pos  <= pos_next;
      tbeg <= tbeg_next;
      line <= line_next;
      cand <= cand_next;
    end
  end

endmodule

// File: rtl/sll_queue.sv
// ----------------------------------------------------------------------------
// sll_queue
// shifting token queue, up to three writes and one read per cycle
// ----------------------------------------------------------------------------
module sll_queue import sll_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  input  logic               pop,
  output token_t             head,
  output logic [LEVEL_W-1:0] level
);

  token_t               slot [QUEUE_DEPTH];
  token_t               slot_next [QUEUE_DEPTH];
  logic [LEVEL_W-1:0]   base;
  logic [LEVEL_W-1:0]   level_next;

  always_comb begin
    logic [LEVEL_W-1:0] offs;
    base = pop ? level - 1'b1 : level;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      slot_next[i] = pop ? slot[i + 1] : slot[i];
    end
    slot_next[QUEUE_DEPTH-1] = slot[QUEUE_DEPTH-1];
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offs = LEVEL_W'(i) - base;
      if (LEVEL_W'(i) >= base && offs < LEVEL_W'(push.count)) begin
        slot_next[i] = push.tok[offs[1:0]];
      end
    end
    level_next = base + LEVEL_W'(push.count);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  assign head = slot[0];

endmodule
